/* rtl/core/chained_hash_set_defines.svh */
// Assertion macros shared by the hash set modules.
`ifndef CHAINED_HASH_SET_DEFINES_SVH
`define CHAINED_HASH_SET_DEFINES_SVH

// Checks that a condition implies a consequence on the same edge.
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/chs_pkg.sv */
// Shared types and constants of the chained hash set.
package chs_pkg;

    localparam int MAX_BUCKETS_DEF = 64;
    localparam int POOL_NODES_DEF  = 1024;
    localparam int KEY_BITS_DEF    = 32;

    localparam int CFG_BITS    = 7;
    localparam int STATUS_BITS = 3;
    localparam int BIDX_BITS   = 6;

    localparam logic [STATUS_BITS-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

    localparam logic MODE_STORE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HEAD,
        B_READ,
        B_CMP,
        B_DONE
    } t_back_state;

endpackage

/* rtl/core/chs_front.sv */
// Front end: accepts items and reduces the key to a bucket by restoring division.
module chs_front
    import chs_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int DW = $clog2(MAX_BUCKETS + 1) + 1,
    localparam int CW = $clog2(KEY_BITS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_mode,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [CFG_BITS-1:0] i_bucket_count,
    input  logic                i_q_full,
    output logic                o_busy,
    output logic                o_push,
    output logic                o_push_mode,
    output logic [KEY_BITS-1:0] o_push_key,
    output logic [BW-1:0]       o_push_bucket
);
    t_front_state r_state, n_state;
    logic [KEY_BITS-1:0] r_key, r_quo;
    logic [DW-1:0]       r_rem, r_div;
    logic [CW-1:0]       r_cnt;
    logic                r_mode;
    logic [DW-1:0]       w_eff;
    logic [DW:0]         w_shift;
    logic                w_start_ok;

    // Bucket count of zero acts as one; values above the table size saturate.
    always_comb begin
        if (i_bucket_count == '0) begin
            w_eff = DW'(1);
        end else if (32'(i_bucket_count) > 32'(MAX_BUCKETS)) begin
            w_eff = DW'(MAX_BUCKETS);
        end else begin
            w_eff = DW'(i_bucket_count);
        end
    end

    assign w_start_ok = i_start && (r_state == F_IDLE);
    assign w_shift = {r_rem, r_quo[KEY_BITS-1]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_start) n_state = F_DIV;
            F_DIV:  if (r_cnt == CW'(1)) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != F_IDLE);
        o_push = (r_state == F_PUSH) && !i_q_full;
    end

    assign o_push_mode   = r_mode;
    assign o_push_key    = r_key;
    assign o_push_bucket = BW'(r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_ok) begin
            r_key  <= i_key;
            r_quo  <= i_key;
            r_mode <= i_mode;
            r_rem  <= '0;
            r_div  <= w_eff;
            r_cnt  <= CW'(KEY_BITS);
        end else if (r_state == F_DIV) begin
            r_cnt <= r_cnt - CW'(1);
            r_quo <= r_quo << 1;
            if (w_shift >= {1'b0, r_div}) begin
                r_rem <= DW'(w_shift - {1'b0, r_div});
            end else begin
                r_rem <= DW'(w_shift);
            end
        end
    end

    `include "chained_hash_set_defines.svh"
    `CHS_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == F_PUSH, r_rem < r_div, "remainder out of range")
    `CHS_ASSERT_NEXT(a_start_divides, i_clk, i_rst_n, w_start_ok, r_state == F_DIV, "start did not enter division")
    `CHS_ASSERT_IMP(a_push_state, i_clk, i_rst_n, o_push, r_state == F_PUSH, "push outside push state")
endmodule

/* rtl/core/chs_queue.sv */
// Two-entry queue between the front and back ends.
module chs_queue
    import chs_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    `include "chained_hash_set_defines.svh"
    `CHS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "queue overflow")
    `CHS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue underflow")
    `CHS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "queue count invalid")
endmodule

/* rtl/core/chs_back.sv */
// Back end: walks a bucket chain in the node memories and inserts new keys.
module chs_back
    import chs_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = POOL_NODES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int NW = $clog2(POOL_NODES + 1),
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  logic                   i_mode,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [BW-1:0]          i_bucket,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [BIDX_BITS-1:0]   o_bucket_index
);
    localparam logic [NW-1:0] NULL_NODE = NW'(POOL_NODES);

    t_back_state r_state, n_state;
    logic [NW-1:0]       r_head [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_head_vld;
    logic [KEY_BITS-1:0] r_node_key [POOL_NODES];
    logic [NW-1:0]       r_node_link [POOL_NODES];
    logic [KEY_BITS-1:0] r_rd_key;
    logic [NW-1:0]       r_rd_link;
    logic [NW-1:0]       r_used, r_node, r_first;
    logic [NW:0]         r_steps;
    logic                r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [BW-1:0]       r_bucket;
    logic [STATUS_BITS-1:0] r_status;
    logic                r_valid;
    logic                w_hit, w_walk, w_insert;
    logic [STATUS_BITS-1:0] w_status;

    // The walk continues while the node is one that has been handed out and the step count is below the pool size.
    assign w_walk = (r_node < r_used) && (r_steps < (NW+1)'(POOL_NODES));
    assign w_hit  = (r_rd_key == r_key);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_HEAD;
            B_HEAD: n_state = B_READ;
            B_READ: n_state = w_walk ? B_CMP : B_DONE;
            B_CMP:  n_state = w_hit ? B_DONE : B_READ;
            B_DONE: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == B_IDLE) && !i_q_empty;
        w_status = ST_NOT_FOUND;
        w_insert = 1'b0;
        if (r_state == B_CMP && w_hit) begin
            w_status = (r_mode == MODE_SEARCH) ? ST_FOUND : ST_DUPLICATE;
        end else if (r_mode == MODE_SEARCH) begin
            w_status = ST_NOT_FOUND;
        end else if (r_used >= NULL_NODE) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_STORED;
            w_insert = (r_state == B_READ) && !w_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_head_vld <= '0;
            r_used <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if ((r_state == B_READ && !w_walk) || (r_state == B_CMP && w_hit)) begin
                r_valid <= 1'b1;
            end
            if (w_insert) begin
                r_head_vld[r_bucket] <= 1'b1;
                r_used <= r_used + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_head[r_bucket] <= r_used;
            r_node_key[AW'(r_used)]  <= r_key;
            r_node_link[AW'(r_used)] <= r_first;
        end
        r_rd_key  <= r_node_key[AW'(r_node)];
        r_rd_link <= r_node_link[AW'(r_node)];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mode <= i_mode;
            r_key <= i_key;
            r_bucket <= i_bucket;
        end
        if (r_state == B_HEAD) begin
            r_node  <= r_head_vld[r_bucket] ? r_head[r_bucket] : NULL_NODE;
            r_first <= r_head_vld[r_bucket] ? r_head[r_bucket] : NULL_NODE;
            r_steps <= '0;
        end else if (r_state == B_CMP) begin
            r_node  <= r_rd_link;
            r_steps <= r_steps + (NW+1)'(1);
        end
        if ((r_state == B_READ) || (r_state == B_CMP)) r_status <= w_status;
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_bucket_index = BIDX_BITS'(r_bucket);

    `include "chained_hash_set_defines.svh"
    `CHS_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= NULL_NODE, "pool count overrun")
    `CHS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_insert, r_used == $past(r_used) + NW'(1), "insert lost")
    `CHS_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == B_DONE, !o_valid, "extra result")
endmodule

/* rtl/core/chained_hash_set.sv */
// Top level of the chained hash set.
// An item is taken when start is high and busy low. The front end reduces the key modulo
// the bucket count with a one-bit-per-cycle divider. It then hands the item to a two-entry
// queue, so busy is high from each accepted item until the queue has taken it. The back end
// walks the bucket chain in node memory and gives one result with o_valid for one cycle. It
// takes the next item from the queue only once it is through with the last one.
// With short chains the divider sets the accept rate. With long chains the back end falls
// behind, the queue fills and busy stays high until it drains, so the chain walk then sets the
// rate as well. Results cannot be held off. No clearing pass is needed after reset.
module chained_hash_set
    import chs_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = POOL_NODES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_BITS-1:0]    i_cfg_wdata,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_mode,
    input  logic [KEY_BITS-1:0]    i_key,
    output logic                   o_valid,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [BIDX_BITS-1:0]   o_bucket_index
);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int QW = 1 + KEY_BITS + BW;

    logic [CFG_BITS-1:0] r_bucket_count;
    logic                w_push, w_pop, w_full, w_empty, w_fmode, w_front_busy;
    logic [KEY_BITS-1:0] w_fkey;
    logic [BW-1:0]       w_fbucket;
    logic [QW-1:0]       w_qout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CFG_BITS'(61);
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_wdata;
        end
    end

    assign busy = w_front_busy;

    chs_front #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_mode, .i_key,
        .i_bucket_count(r_bucket_count), .i_q_full(w_full), .o_busy(w_front_busy),
        .o_push(w_push), .o_push_mode(w_fmode), .o_push_key(w_fkey),
        .o_push_bucket(w_fbucket)
    );

    chs_queue #(.WIDTH(QW)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data({w_fmode, w_fkey, w_fbucket}),
        .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty), .o_data(w_qout)
    );

    chs_back #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_empty(w_empty), .i_mode(w_qout[QW-1]),
        .i_key(w_qout[QW-2:BW]), .i_bucket(w_qout[BW-1:0]), .o_pop(w_pop),
        .o_valid, .o_status, .o_bucket_index
    );
endmodule

/* tb/tb_chained_hash_set.sv */
// Self-checking testbench for the chained hash set: directed table, then random phases.
module tb_chained_hash_set;
    import chs_pkg::*;

    localparam int NODES      = POOL_NODES_DEF;
    localparam int BUCKETS    = MAX_BUCKETS_DEF;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 100;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic                    mode;
        logic [31:0]             key;
        logic [CFG_BITS-1:0]     cfg;
        bit                      typed;
        logic [STATUS_BITS-1:0]  status;
        logic [BIDX_BITS-1:0]    bidx;
    } t_row;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [BIDX_BITS-1:0]   bidx;
    } t_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0]    i_cfg_wdata = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_mode = MODE_STORE;
    logic [31:0]            i_key = '0;
    logic                   o_valid;
    logic [STATUS_BITS-1:0] o_status;
    logic [BIDX_BITS-1:0]   o_bucket_index;

    chained_hash_set dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy),
        .i_mode(i_mode), .i_key(i_key),
        .o_valid(o_valid), .o_status(o_status), .o_bucket_index(o_bucket_index)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the set.
    logic [CFG_BITS-1:0] shadow_count;
    logic [10:0]         shadow_head [BUCKETS];
    logic [31:0]         shadow_key  [NODES];
    logic [10:0]         shadow_link [NODES];
    int                  shadow_used;
    logic [31:0]         known_keys [$];

    t_reply pending_replies [$];
    int     fails = 0;
    int     stall_cycles = 0;
    int     items_sent = 0;
    int     cfg_writes = 0;
    int     status_seen [5] = '{default: 0};

    function automatic t_reply hash_set_lookup(input logic mode, input logic [31:0] key);
        t_reply r;
        int     nb;
        int     node;
        int     steps;
        bit     present;
        nb = (shadow_count == 0) ? 1 : (shadow_count > BUCKETS) ? BUCKETS : shadow_count;
        r.bidx = BIDX_BITS'(key % nb);
        node = shadow_head[r.bidx];
        steps = 0;
        present = 1'b0;
        while (!present && node < shadow_used && node < NODES && steps < NODES) begin
            if (shadow_key[node] == key)
                present = 1'b1;
            else
                node = shadow_link[node];
            steps++;
        end
        if (mode == MODE_SEARCH) begin
            r.status = present ? ST_FOUND : ST_NOT_FOUND;
        end else if (present) begin
            r.status = ST_DUPLICATE;
        end else if (shadow_used >= NODES) begin
            r.status = ST_FULL;
        end else begin
            shadow_key[shadow_used]  = key;
            shadow_link[shadow_used] = shadow_head[r.bidx];
            shadow_head[r.bidx]      = 11'(shadow_used);
            shadow_used++;
            known_keys.push_back(key);
            r.status = ST_STORED;
        end
        return r;
    endfunction

    // Results cannot be held off, so every strobe is taken on the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                $error("result with nothing outstanding: status %0d bucket %0d",
                       o_status, o_bucket_index);
                fails++;
            end else begin
                t_reply want;
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    fails++;
                end
                if (o_bucket_index !== want.bidx) begin
                    $error("bucket_index expected %0d got %0d", want.bidx, o_bucket_index);
                    fails++;
                end
                if (o_status <= ST_FULL)
                    status_seen[o_status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60)
            return 0;
        else if (p < 90)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic send_item(input logic mode, input logic [31:0] key,
                             input bit typed, input t_reply typed_reply);
        int     gap;
        t_reply r;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_mode <= mode;
        i_key  <= key;
        do @(posedge i_clk); while (busy);
        r = hash_set_lookup(mode, key);
        pending_replies.push_back(typed ? typed_reply : r);
        items_sent++;
    endtask

    // Configuration is only written with nothing in flight.
    task automatic write_count(input logic [CFG_BITS-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_count = value;
        cfg_writes++;
    endtask

    // 0xFFFFFFFF lands in bucket 56 with 61 buckets and in bucket 63 with 64.
    t_row directed [] = '{
        '{ROW_ITEM, MODE_SEARCH, 32'd0,          7'd0,   1, ST_NOT_FOUND, 6'd0},
        '{ROW_ITEM, MODE_STORE,  32'd0,          7'd0,   1, ST_STORED,    6'd0},
        '{ROW_ITEM, MODE_STORE,  32'd0,          7'd0,   1, ST_DUPLICATE, 6'd0},
        '{ROW_ITEM, MODE_SEARCH, 32'd0,          7'd0,   1, ST_FOUND,     6'd0},
        '{ROW_ITEM, MODE_STORE,  32'hFFFFFFFF,   7'd0,   1, ST_STORED,    6'd56},
        '{ROW_ITEM, MODE_SEARCH, 32'hFFFFFFFF,   7'd0,   1, ST_FOUND,     6'd56},
        '{ROW_ITEM, MODE_STORE,  32'd61,         7'd0,   1, ST_STORED,    6'd0},
        '{ROW_ITEM, MODE_SEARCH, 32'd0,          7'd0,   1, ST_FOUND,     6'd0},
        '{ROW_ITEM, MODE_STORE,  32'h5555AAAA,   7'd0,   0, ST_STORED,    6'd0},
        '{ROW_CFG,  MODE_STORE,  32'd0,          7'd0,   0, ST_STORED,    6'd0},
        '{ROW_ITEM, MODE_SEARCH, 32'd0,          7'd0,   1, ST_FOUND,     6'd0},
        '{ROW_ITEM, MODE_SEARCH, 32'hFFFFFFFF,   7'd0,   1, ST_NOT_FOUND, 6'd0},
        '{ROW_ITEM, MODE_STORE,  32'd5,          7'd0,   1, ST_STORED,    6'd0},
        '{ROW_CFG,  MODE_STORE,  32'd0,          7'd127, 0, ST_STORED,    6'd0},
        '{ROW_ITEM, MODE_STORE,  32'hFFFFFFFF,   7'd0,   1, ST_STORED,    6'd63},
        '{ROW_ITEM, MODE_SEARCH, 32'd127,        7'd0,   1, ST_NOT_FOUND, 6'd63},
        '{ROW_CFG,  MODE_STORE,  32'd0,          7'd64,  0, ST_STORED,    6'd0},
        '{ROW_ITEM, MODE_SEARCH, 32'd64,         7'd0,   1, ST_NOT_FOUND, 6'd0},
        '{ROW_ITEM, MODE_STORE,  32'hAAAA5555,   7'd0,   0, ST_STORED,    6'd0},
        '{ROW_CFG,  MODE_STORE,  32'd0,          7'd1,   0, ST_STORED,    6'd0},
        '{ROW_ITEM, MODE_STORE,  32'h80000000,   7'd0,   1, ST_STORED,    6'd0},
        '{ROW_ITEM, MODE_SEARCH, 32'h7FFFFFFF,   7'd0,   0, ST_STORED,    6'd0},
        '{ROW_CFG,  MODE_STORE,  32'd0,          7'd61,  0, ST_STORED,    6'd0}
    };

    logic [CFG_BITS-1:0] phase_count [8] = '{7'd61, 7'd64, 7'd127, 7'd37,
                                             7'd0, 7'd100, 7'd13, 7'd1};
    int                  phase_items [8] = '{300, 250, 200, 200, 15, 150, 100, 15};

    initial begin
        t_reply typed_reply;
        int     p;
        logic   mode;
        logic [31:0] key;
        shadow_count = 7'd61;
        shadow_used  = 0;
        foreach (shadow_head[b]) shadow_head[b] = 11'(NODES);
        foreach (shadow_key[n]) begin
            shadow_key[n]  = '0;
            shadow_link[n] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                write_count(directed[i].cfg);
            end else begin
                typed_reply.status = directed[i].status;
                typed_reply.bidx   = directed[i].bidx;
                send_item(directed[i].mode, directed[i].key, directed[i].typed, typed_reply);
            end
        end

        foreach (phase_count[ph]) begin
            write_count(phase_count[ph]);
            repeat (phase_items[ph]) begin
                p = $urandom_range(99);
                // Fill the pool quickly so that the full case is reached.
                if (shadow_used < NODES && p < 85) begin
                    mode = MODE_STORE;
                    key  = $urandom();
                end else if (p < 92 && known_keys.size() > 0) begin
                    mode = 1'($urandom_range(1));
                    key  = known_keys[$urandom_range(known_keys.size() - 1)];
                end else begin
                    mode = 1'($urandom_range(1));
                    key  = $urandom();
                end
                send_item(mode, key, 1'b0, typed_reply);
            end
        end

        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("%0d items over %0d bucket count writes, %0d pool nodes used", items_sent,
                 cfg_writes, shadow_used);
        $display("stored %0d, duplicate %0d, found %0d, missing %0d, pool full %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/chs_pkg.sv
rtl/core/chs_front.sv
rtl/core/chs_queue.sv
rtl/core/chs_back.sv
rtl/core/chained_hash_set.sv
tb/tb_chained_hash_set.sv
